// ===== sv/csq_pkg.sv =====
// Shared types and constants for the counting semaphore with FIFO wait queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package csq_pkg;

	// Width of the signed semaphore count and its saturation limits.
	localparam int unsigned COUNT_W = 9;
	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 9'sh100;

	// Field widths of one transfer.
	localparam int unsigned TID_W  = 4;
	localparam int unsigned INIT_W = 8;

	// Operation codes.
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} csq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} csq_cmd_t;

endpackage

// ===== sv/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a FIFO wait queue of MAX_WAITERS thread ids.
// Each item is captured from the input transfer, executed with the registered queue
// read, then presented; the controller steps through an idle, an execute and an
// output state on every item and takes no new item until the output transfer
// completes, so an output stall holds the flow.
// Reset: count is 1, the queue is empty; queue memory contents are undefined.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue import csq_pkg::*; #(
	parameter int unsigned MAX_WAITERS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [TID_W-1:0]          thread_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      blocked,
	output logic                      woken_valid,
	output logic [TID_W-1:0]          woken_thread,
	output logic signed [COUNT_W-1:0] count_now,
	output logic                      queue_overflow,
	input  logic                      initial_count_we,
	input  logic [INIT_W-1:0]         initial_count
);

	csq_cmd_t cmd;

	// Sequencing of transfers.
	csq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Count, queue and result storage.
	csq_dp #(
		.MAX_WAITERS (MAX_WAITERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.opcode           (opcode),
		.thread_id        (thread_id),
		.initial_count_we (initial_count_we),
		.initial_count    (initial_count),
		.blocked          (blocked),
		.woken_valid      (woken_valid),
		.woken_thread     (woken_thread),
		.count_now        (count_now),
		.queue_overflow   (queue_overflow)
	);

endmodule

// ===== sv/csq_ctrl.sv =====
// Controller state machine for the counting semaphore.
// Depends on csq_pkg; drives the datapath through csq_cmd_t commands.
`timescale 1ns / 1ps

module csq_ctrl import csq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output csq_cmd_t cmd
);

	csq_state_t state_q;
	csq_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Output and command decode.
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/csq_dp.sv =====
// Datapath for the counting semaphore: count register, wait queue memory,
// queue pointers and the result register. Depends on csq_pkg.
`timescale 1ns / 1ps

module csq_dp import csq_pkg::*; #(
	parameter int unsigned MAX_WAITERS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csq_cmd_t                  cmd,
	input  logic                      opcode,
	input  logic [TID_W-1:0]          thread_id,
	input  logic                      initial_count_we,
	input  logic [INIT_W-1:0]         initial_count,
	output logic                      blocked,
	output logic                      woken_valid,
	output logic [TID_W-1:0]          woken_thread,
	output logic signed [COUNT_W-1:0] count_now,
	output logic                      queue_overflow
);

	localparam int unsigned PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int unsigned LVL_W = $clog2(MAX_WAITERS + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WAITERS - 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(MAX_WAITERS);

	logic [TID_W-1:0]          wait_mem [MAX_WAITERS];
	logic [TID_W-1:0]          rdata_q;
	logic                      op_q;
	logic [TID_W-1:0]          tid_q;
	logic signed [COUNT_W-1:0] count_q;
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic [LVL_W-1:0]          level_q;

	logic                      take_unit;
	logic                      enqueue;
	logic                      dequeue;
	logic                      overflow;
	logic signed [COUNT_W-1:0] count_next;
	logic [PTR_W-1:0]          head_inc;
	logic [PTR_W-1:0]          tail_inc;

	// Item capture; the head entry is read at the same edge so that the
	// registered read data is ready in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			tid_q   <= thread_id;
			rdata_q <= wait_mem[head_q];
		end
	end

	// Wait queue memory write at the tail.
	always_ff @(posedge clk) begin
		if (enqueue) begin
			wait_mem[tail_q] <= tid_q;
		end
	end

	// Pointer wrap.
	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);

	// Operation decode and count update.
	always_comb begin
		take_unit  = 1'b0;
		enqueue    = 1'b0;
		dequeue    = 1'b0;
		overflow   = 1'b0;
		count_next = count_q;
		if (op_q == OP_ACQUIRE) begin
			if (count_q > 9'sd0) begin
				take_unit  = 1'b1;
				count_next = count_q - 9'sd1;
			end else if (level_q == LVL_FULL) begin
				overflow = 1'b1;
			end else begin
				enqueue = cmd.exec;
				if (count_q != COUNT_MIN) count_next = count_q - 9'sd1;
			end
		end else begin
			if (count_q != COUNT_MAX) count_next = count_q + 9'sd1;
			dequeue = cmd.exec && (level_q != '0);
		end
	end

	// Semaphore count and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 9'sd1;
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (initial_count_we) begin
				count_q <= signed'({1'b0, initial_count});
			end else if (cmd.exec) begin
				count_q <= count_next;
			end
			if (enqueue) begin
				tail_q  <= tail_inc;
				level_q <= level_q + LVL_W'(1);
			end else if (dequeue) begin
				head_q  <= head_inc;
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			blocked        <= (op_q == OP_ACQUIRE) && !take_unit && !overflow;
			woken_valid    <= dequeue;
			woken_thread   <= dequeue ? rdata_q : '0;
			count_now      <= count_next;
			queue_overflow <= overflow;
		end
	end

endmodule

// ===== sim/counting_semaphore_wait_queue_tb.sv =====
// Self-checking testbench for the counting semaphore with FIFO wait queue.
// Needs csq_pkg and counting_semaphore_wait_queue; drives random P/V traffic
// with bursty input, patterned output stalls and count reloads between phases.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_tb;
	import csq_pkg::*;

	localparam int unsigned WAIT_DEPTH  = 16;
	localparam int unsigned LONG_HOLD   = 150;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 56;

	// Count loaded per phase (unused in RANDOM_COUNT_PHASE) and the share of acquires.
	localparam int PHASE_COUNT [PHASES] = '{0, 255, 1, 3, 0, 0, 255, 2};
	localparam int ACQUIRE_PCT [PHASES] = '{60, 35, 65, 55, 50, 80, 45, 60};
	localparam int RANDOM_COUNT_PHASE   = 4;

	typedef struct {
		logic             op;
		logic [TID_W-1:0] tid;
	} sem_op_t;

	typedef struct {
		logic                      blocked;
		logic                      woken_valid;
		logic [TID_W-1:0]          woken_thread;
		logic signed [COUNT_W-1:0] count_now;
		logic                      queue_overflow;
	} sem_result_t;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      opcode = OP_ACQUIRE;
	logic [TID_W-1:0]          thread_id = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      blocked;
	logic                      woken_valid;
	logic [TID_W-1:0]          woken_thread;
	logic signed [COUNT_W-1:0] count_now;
	logic                      queue_overflow;
	logic                      initial_count_we = 1'b0;
	logic [INIT_W-1:0]         initial_count = '0;

	// Items waiting to be offered and results waiting to come out.
	sem_op_t     op_queue [$];
	sem_result_t results_due [$];
	int unsigned mismatches = 0;
	bit          in_took = 1'b0;

	// Predicted semaphore state.
	int               pred_count = 1;
	logic [TID_W-1:0] wait_ids [WAIT_DEPTH];
	int unsigned      wait_rd = 0;
	int unsigned      wait_wr = 0;
	int unsigned      wait_depth = 0;

	// Sender and receiver pacing.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;

	counting_semaphore_wait_queue #(
		.MAX_WAITERS(WAIT_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.thread_id(thread_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blocked(blocked),
		.woken_valid(woken_valid),
		.woken_thread(woken_thread),
		.count_now(count_now),
		.queue_overflow(queue_overflow),
		.initial_count_we(initial_count_we),
		.initial_count(initial_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one P or V to the predicted state and return the result it causes.
	function automatic sem_result_t apply_sem_op(logic op, logic [TID_W-1:0] tid);
		sem_result_t r;
		r = '{default: '0};
		if (op == OP_ACQUIRE) begin
			if (pred_count > 0) begin
				pred_count--;
			end else if (wait_depth >= WAIT_DEPTH) begin
				// A full queue refuses the acquire and leaves the count alone.
				r.queue_overflow = 1'b1;
			end else begin
				if (pred_count > int'(COUNT_MIN))
					pred_count--;
				wait_ids[wait_wr] = tid;
				wait_wr = (wait_wr + 1) % WAIT_DEPTH;
				wait_depth++;
				r.blocked = 1'b1;
			end
		end else begin
			if (pred_count < int'(COUNT_MAX))
				pred_count++;
			if (wait_depth > 0) begin
				r.woken_valid = 1'b1;
				r.woken_thread = wait_ids[wait_rd];
				wait_rd = (wait_rd + 1) % WAIT_DEPTH;
				wait_depth--;
			end
		end
		r.count_now = pred_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string field, logic signed [15:0] want, logic signed [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Record input transfers and check every output transfer against the oldest prediction.
	always @(posedge clk) begin : monitor
		sem_result_t want;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_took)
				results_due.push_back(apply_sem_op(opcode, thread_id));
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no prediction waiting");
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("blocked", want.blocked, blocked);
					check_field("woken_valid", want.woken_valid, woken_valid);
					check_field("woken_thread", want.woken_thread, woken_thread);
					check_field("count_now", want.count_now, count_now);
					check_field("queue_overflow", want.queue_overflow, queue_overflow);
				end
			end
		end
	end

	// Offer queued items in bursts of random length separated by random gaps.
	always @(negedge clk) begin : sender
		sem_op_t next_op;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (op_queue.size() != 0) begin
				next_op = op_queue.pop_front();
				in_valid <= 1'b1;
				opcode <= next_op.op;
				thread_id <= next_op.tid;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output in changing modes, with a long hold-off when one is requested.
	always @(negedge clk) begin : receiver
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 99) < 30);
				end
				RX_HEAVY: begin
					out_stall <= ($urandom_range(0, 99) < 75);
				end
				default: begin
					out_stall <= ((mode_left % 4) == 0);
				end
			endcase
		end
	end

	task automatic queue_op(logic op, logic [TID_W-1:0] tid);
		sem_op_t item;
		item.op = op;
		item.tid = tid;
		op_queue.push_back(item);
	endtask

	// Block until every item has been taken and every result has come out.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (op_queue.size() != 0 || in_valid || results_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// Reload the count; called only while the block is idle, on a falling edge.
	task automatic load_count(logic [INIT_W-1:0] value);
		initial_count_we <= 1'b1;
		initial_count <= value;
		pred_count = value;
		@(negedge clk);
		initial_count_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned count_value;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default count of one: take it, block one thread, wake it, then give back.
		queue_op(OP_ACQUIRE, 4'd0);
		queue_op(OP_ACQUIRE, 4'd15);
		queue_op(OP_RELEASE, 4'd15);
		queue_op(OP_RELEASE, 4'd0);
		wait_idle();

		// Count zero: fill the queue, overflow it once, then wake the two oldest.
		load_count(8'd0);
		for (int i = 0; i < WAIT_DEPTH + 1; i++)
			queue_op(OP_ACQUIRE, TID_W'(i));
		queue_op(OP_RELEASE, 4'd9);
		queue_op(OP_RELEASE, 4'd6);
		wait_idle();

		// Reload to the maximum with waiters still queued; the release saturates.
		load_count(8'd255);
		queue_op(OP_RELEASE, 4'd3);
		queue_op(OP_ACQUIRE, 4'd12);

		// Random phases, each starting from a fresh count with the queue carried over.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			count_value = (p == RANDOM_COUNT_PHASE) ? $urandom_range(0, 255) : PHASE_COUNT[p];
			load_count(INIT_W'(count_value));
			if (p == 0 || p == 5)
				hold_requests++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_op(($urandom_range(1, 100) <= ACQUIRE_PCT[p]) ? OP_ACQUIRE : OP_RELEASE,
					TID_W'($urandom));
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/csq_pkg.sv
sv/csq_ctrl.sv
sv/csq_dp.sv
sv/counting_semaphore_wait_queue.sv
sim/counting_semaphore_wait_queue_tb.sv
